[rtl/core/cri_pkg.sv]
// Shared types and constants of the Catmull-Rom quaternion interpolator.
package cri_pkg;

   localparam int COMP_FRAC_BITS_DEF = 14;
   localparam int COMP_W = 16;
   localparam int COEF_W = 36;
   localparam int ACC_W  = 64;
   localparam int SQ_W   = 60;
   localparam int ROOT_W = 31;

   typedef enum logic [3:0] {
      ST_IDLE, ST_POLY1, ST_POLY2, ST_HERM, ST_MAC, ST_ABS, ST_NORM, ST_SQUARE,
      ST_ROOT_LD, ST_ROOT, ST_DIV_LD, ST_DIV, ST_DONE
   } state_type;

   typedef enum logic [1:0] {TERM_P1, TERM_P2, TERM_M1, TERM_M2} term_type;

   typedef struct packed {
      logic     load;
      logic     negate;
      logic     clear;
      logic     mac;
      term_type sel;
      logic     absolute;
      logic     shift8;
      logic     shift1;
      logic     square;
      logic     div_start;
      logic     div_step;
   } lane_ctrl_type;

   typedef struct packed {
      logic start;
      logic step;
   } root_ctrl_type;

endpackage

[rtl/core/cri_lane.sv]
// One component lane: window column, Hermite accumulation, scaling, square and divider.
module cri_lane #(
   parameter int COMP_FRAC_BITS = cri_pkg::COMP_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  cri_pkg::lane_ctrl_type                 ctrl,
   input  logic signed [cri_pkg::COMP_W-1:0]      load_point,
   input  logic signed [cri_pkg::COEF_W-1:0]      coef_p1,
   input  logic signed [cri_pkg::COEF_W-1:0]      coef_p2,
   input  logic signed [cri_pkg::COEF_W-1:0]      coef_m1,
   input  logic signed [cri_pkg::COEF_W-1:0]      coef_m2,
   input  logic [cri_pkg::ROOT_W-1:0]             root,
   output logic signed [2*cri_pkg::COMP_W-1:0]    dot_term,
   output logic [cri_pkg::ACC_W-1:0]              mag,
   output logic [cri_pkg::SQ_W-1:0]               sq,
   output logic signed [cri_pkg::COMP_W-1:0]      result
);
   import cri_pkg::*;

   localparam int NUM_W = ROOT_W + COMP_FRAC_BITS;
   localparam int OPD_W = COMP_W + 1;
   localparam int PRD_W = COEF_W + OPD_W;

   logic signed [COMP_W-1:0] p_ff [4];
   logic signed [COMP_W-1:0] new_point;
   logic signed [COEF_W-1:0] coef;
   logic signed [OPD_W-1:0]  opnd;
   logic signed [PRD_W-1:0]  product;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]         mag_ff;
   logic                     neg_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [ROOT_W:0]          rem_ff;
   logic [ROOT_W:0]          rem_sh;
   logic                     ge;
   logic                     big;

   assign dot_term = load_point * p_ff[3];

   always_comb begin
      if (ctrl.negate) begin
         if (load_point == {1'b1, {(COMP_W-1){1'b0}}}) begin
            new_point = {1'b0, {(COMP_W-1){1'b1}}};
         end else begin
            new_point = -load_point;
         end
      end else begin
         new_point = load_point;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= '{default: '0};
      end else if (ctrl.load) begin
         p_ff[0] <= p_ff[1];
         p_ff[1] <= p_ff[2];
         p_ff[2] <= p_ff[3];
         p_ff[3] <= new_point;
      end
   end

   always_comb begin
      case (ctrl.sel)
         TERM_P1: begin
            coef = coef_p1;
            opnd = {p_ff[1][COMP_W-1], p_ff[1]};
         end
         TERM_P2: begin
            coef = coef_p2;
            opnd = {p_ff[2][COMP_W-1], p_ff[2]};
         end
         TERM_M1: begin
            coef = coef_m1;
            opnd = {p_ff[2][COMP_W-1], p_ff[2]} - {p_ff[0][COMP_W-1], p_ff[0]};
         end
         default: begin
            coef = coef_m2;
            opnd = {p_ff[3][COMP_W-1], p_ff[3]} - {p_ff[1][COMP_W-1], p_ff[1]};
         end
      endcase
   end

   assign product = coef * opnd;

   assign rem_sh = {rem_ff[ROOT_W-1:0], num_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, root};

   always_ff @(posedge clock) begin
      if (ctrl.mac) begin
         acc_ff <= (ctrl.clear ? '0 : acc_ff) + ACC_W'(product);
      end
      if (ctrl.absolute) begin
         mag_ff <= acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);
         neg_ff <= acc_ff[ACC_W-1];
      end else if (ctrl.shift8) begin
         mag_ff <= mag_ff >> 8;
      end else if (ctrl.shift1) begin
         mag_ff <= mag_ff >> 1;
      end
      if (ctrl.square) begin
         sq_ff <= mag_ff[29:0] * mag_ff[29:0];
      end
      if (ctrl.div_start) begin
         num_ff <= NUM_W'({mag_ff[29:0], {COMP_FRAC_BITS{1'b0}}})
                   + NUM_W'(root >> 1);
         rem_ff <= '0;
      end else if (ctrl.div_step) begin
         rem_ff <= ge ? rem_sh - {1'b0, root} : rem_sh;
         num_ff <= {num_ff[NUM_W-2:0], ge};
      end
   end

   assign mag = mag_ff;
   assign sq  = sq_ff;
   assign big = |num_ff[NUM_W-1:COMP_W];

   always_comb begin
      if (neg_ff) begin
         if (big || (num_ff[COMP_W-1] && (|num_ff[COMP_W-2:0]))) begin
            result = {1'b1, {(COMP_W-1){1'b0}}};
         end else begin
            result = -$signed(num_ff[COMP_W-1:0]);
         end
      end else begin
         if (big || num_ff[COMP_W-1]) begin
            result = {1'b0, {(COMP_W-1){1'b1}}};
         end else begin
            result = $signed(num_ff[COMP_W-1:0]);
         end
      end
   end

endmodule

[rtl/core/cri_root.sv]
// Merging stage: sum of the lane squares and iterative integer square root.
module cri_root (
   input  logic                          clock,
   input  logic                          reset,
   input  cri_pkg::root_ctrl_type        ctrl,
   input  logic [cri_pkg::SQ_W-1:0]      sq0,
   input  logic [cri_pkg::SQ_W-1:0]      sq1,
   input  logic [cri_pkg::SQ_W-1:0]      sq2,
   input  logic [cri_pkg::SQ_W-1:0]      sq3,
   output logic [cri_pkg::ROOT_W-1:0]    root
);
   import cri_pkg::*;

   logic [63:0] v_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= '0;
      end else if (ctrl.start) begin
         bit_ff <= 64'd1 << 62;
      end else if (ctrl.step) begin
         bit_ff <= bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         v_ff   <= 64'(sq0) + 64'(sq1) + 64'(sq2) + 64'(sq3);
         res_ff <= '0;
      end else if (ctrl.step) begin
         if (v_ff >= trial) begin
            v_ff   <= v_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
      end
   end

   assign root = res_ff[ROOT_W-1:0];

endmodule

[rtl/core/catmull_rom_quaternion_interp.sv]
// Top level of the Catmull-Rom quaternion interpolator: control, Hermite weights and lanes.
// A load transfer leaves the block in the idle state, so it is ready again in the next
// cycle. An evaluate transfer runs the polynomial and Hermite weight states, the
// multiply-accumulate of the terms, the scaling shifts, which depend on the data,
// the 32-step square-root iteration of the merging stage and the bit-serial dividers
// of the four component lanes, which run 31 + COMP_FRAC_BITS steps. A finished result
// waits in the output register while further load transfers are taken.
module catmull_rom_quaternion_interp #(
   parameter int COMP_FRAC_BITS = cri_pkg::COMP_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [cri_pkg::COMP_W-1:0]   req_point_w,
   input  logic signed [cri_pkg::COMP_W-1:0]   req_point_x,
   input  logic signed [cri_pkg::COMP_W-1:0]   req_point_y,
   input  logic signed [cri_pkg::COMP_W-1:0]   req_point_z,
   input  logic [16:0]                         req_param_t,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [cri_pkg::COMP_W-1:0]   rsp_out_w,
   output logic signed [cri_pkg::COMP_W-1:0]   rsp_out_x,
   output logic signed [cri_pkg::COMP_W-1:0]   rsp_out_y,
   output logic signed [cri_pkg::COMP_W-1:0]   rsp_out_z,
   output logic                                rsp_zero_norm
);
   import cri_pkg::*;

   localparam int NUM_W = ROOT_W + COMP_FRAC_BITS;
   localparam int CNT_W = $clog2(NUM_W);

   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [16:0] t_ff;
   logic [32:0] t2_ff;
   logic [32:0] t3_ff;
   logic [49:0] t2t;
   logic [33:0] t3_round;
   logic signed [COEF_W-1:0] c_p1_ff, c_p2_ff, c_m1_ff, c_m2_ff;
   logic signed [COEF_W-1:0] t1s, t2s, t3s;
   lane_ctrl_type lane_ctrl;
   root_ctrl_type root_ctrl;
   logic signed [COMP_W-1:0] lane_point [4];
   logic signed [2*COMP_W-1:0] dot_term [4];
   logic [ACC_W-1:0] mag [4];
   logic [SQ_W-1:0] sq [4];
   logic signed [COMP_W-1:0] result [4];
   logic [ROOT_W-1:0] root;
   logic signed [2*COMP_W+1:0] dot;
   logic [ACC_W-1:0] mag_or;
   logic req_xfer, load_rsp;
   logic rsp_valid_ff;
   logic signed [COMP_W-1:0] out_ff [4];
   logic zero_ff;

   assign lane_point[0] = req_point_w;
   assign lane_point[1] = req_point_x;
   assign lane_point[2] = req_point_y;
   assign lane_point[3] = req_point_z;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;

   assign dot = (2*COMP_W+2)'(dot_term[0]) + (2*COMP_W+2)'(dot_term[1])
              + (2*COMP_W+2)'(dot_term[2]) + (2*COMP_W+2)'(dot_term[3]);
   assign mag_or = mag[0] | mag[1] | mag[2] | mag[3];

   assign t2t      = t2_ff * t_ff;
   assign t3_round = 34'((t2t + 50'd32768) >> 16);
   assign t1s = $signed(COEF_W'({t_ff, 16'b0}));
   assign t2s = $signed(COEF_W'(t2_ff));
   assign t3s = $signed(COEF_W'(t3_ff));

   always_ff @(posedge clock) begin
      if (req_xfer && req_action) begin
         t_ff <= (req_param_t > 17'd65536) ? 17'd65536 : req_param_t;
      end
      if (state_ff == ST_POLY1) begin
         t2_ff <= 33'(t_ff * t_ff);
      end
      if (state_ff == ST_POLY2) begin
         t3_ff <= t3_round[32:0];
      end
      if (state_ff == ST_HERM) begin
         c_p1_ff <= 2 * (2 * t3s - 3 * t2s + (COEF_W'(1) <<< 32));
         c_p2_ff <= 2 * (3 * t2s - 2 * t3s);
         c_m1_ff <= t3s - 2 * t2s + t1s;
         c_m2_ff <= t3s - t2s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      lane_ctrl = '0;
      root_ctrl = '0;
      load_rsp  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_action) begin
                  state_in = ST_POLY1;
               end else begin
                  lane_ctrl.load   = 1'b1;
                  lane_ctrl.negate = dot < 0;
               end
            end
         end
         ST_POLY1: state_in = ST_POLY2;
         ST_POLY2: state_in = ST_HERM;
         ST_HERM: begin
            state_in = ST_MAC;
            cnt_in   = '0;
         end
         ST_MAC: begin
            lane_ctrl.mac   = 1'b1;
            lane_ctrl.clear = (cnt_ff == '0);
            lane_ctrl.sel   = term_type'(cnt_ff[1:0]);
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(3)) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            lane_ctrl.absolute = 1'b1;
            state_in           = ST_NORM;
         end
         ST_NORM: begin
            if (|mag_or[63:38]) begin
               lane_ctrl.shift8 = 1'b1;
            end else if (|mag_or[63:30]) begin
               lane_ctrl.shift1 = 1'b1;
            end else begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            lane_ctrl.square = 1'b1;
            state_in         = ST_ROOT_LD;
         end
         ST_ROOT_LD: begin
            root_ctrl.start = 1'b1;
            cnt_in          = '0;
            state_in        = ST_ROOT;
         end
         ST_ROOT: begin
            root_ctrl.step = 1'b1;
            cnt_in         = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(31)) begin
               state_in = ST_DIV_LD;
            end
         end
         ST_DIV_LD: begin
            lane_ctrl.div_start = 1'b1;
            cnt_in              = '0;
            state_in            = ST_DIV;
         end
         ST_DIV: begin
            lane_ctrl.div_step = 1'b1;
            cnt_in             = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   for (genvar i = 0; i < 4; i++) begin : g_lane
      cri_lane #(
         .COMP_FRAC_BITS(COMP_FRAC_BITS)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .load_point (lane_point[i]),
         .coef_p1    (c_p1_ff),
         .coef_p2    (c_p2_ff),
         .coef_m1    (c_m1_ff),
         .coef_m2    (c_m2_ff),
         .root       (root),
         .dot_term   (dot_term[i]),
         .mag        (mag[i]),
         .sq         (sq[i]),
         .result     (result[i])
      );
   end

   cri_root u_root (
      .clock (clock),
      .reset (reset),
      .ctrl  (root_ctrl),
      .sq0   (sq[0]),
      .sq1   (sq[1]),
      .sq2   (sq[2]),
      .sq3   (sq[3]),
      .root  (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         zero_ff <= (root == '0);
         for (int i = 0; i < 4; i++) begin
            out_ff[i] <= (root == '0) ? '0 : result[i];
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_w     = out_ff[0];
   assign rsp_out_x     = out_ff[1];
   assign rsp_out_y     = out_ff[2];
   assign rsp_out_z     = out_ff[3];
   assign rsp_zero_norm = zero_ff;

endmodule

[verif/tb_top.sv]
// Self-checking testbench of the Catmull-Rom quaternion interpolator, with its own blend predictor.
`timescale 1ns / 100ps

module tb_top;
   import cri_pkg::*;

   localparam int FRAC = COMP_FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic signed [15:0] w, x, y, z;
      logic               zero_norm;
   } blend_type;

   typedef struct {
      logic               action;
      logic signed [15:0] w, x, y, z;
      logic [16:0]        t;
      bit                 typed;
      blend_type          known;
   } req_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_action = 1'b0;
   logic signed [15:0] req_point_w = '0, req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic [16:0] req_param_t = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_out_w, rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_zero_norm;

   catmull_rom_quaternion_interp DUT (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   req_item_type stim_q[$];
   req_item_type cur_item;
   blend_type    blend_q[$];
   longint       window[4][4];
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   int           fail_count = 0;
   int           quiet_cycles = 0;

   task automatic push_point(input req_item_type it);
      longint np[4];
      longint dot;
      dot = 0;
      np[0] = it.w; np[1] = it.x; np[2] = it.y; np[3] = it.z;
      for (int i = 0; i < 4; i++) dot += np[i] * window[3][i];
      if (dot < 0) begin
         for (int i = 0; i < 4; i++) begin
            np[i] = -np[i];
            if (np[i] > 32767) np[i] = 32767;
         end
      end
      for (int i = 0; i < 4; i++) begin
         window[0][i] = window[1][i];
         window[1][i] = window[2][i];
         window[2][i] = window[3][i];
         window[3][i] = np[i];
      end
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic blend_type blend_at(input logic [16:0] t_in);
      blend_type r;
      longint tt, t1, t2, t3, h00, h10, h01, h11;
      longint s[4];
      longint unsigned mag[4];
      bit neg[4];
      longint unsigned maxm, sum, n, q;
      int k;
      longint v;
      tt = t_in;
      if (tt > 65536) tt = 65536;
      t1 = tt << 16;
      t2 = tt * tt;
      t3 = (t2 * tt + 32768) >>> 16;
      h00 = 2 * t3 - 3 * t2 + (64'sd1 <<< 32);
      h10 = t3 - 2 * t2 + t1;
      h01 = 3 * t2 - 2 * t3;
      h11 = t3 - t2;
      maxm = 0;
      sum = 0;
      k = 0;
      for (int i = 0; i < 4; i++) begin
         s[i] = 2 * h00 * window[1][i] + 2 * h01 * window[2][i]
              + h10 * (window[2][i] - window[0][i]) + h11 * (window[3][i] - window[1][i]);
         neg[i] = s[i] < 0;
         mag[i] = neg[i] ? longint'(-s[i]) : longint'(s[i]);
         if (mag[i] > maxm) maxm = mag[i];
      end
      while ((maxm >> k) >= (64'd1 << 30)) k++;
      for (int i = 0; i < 4; i++) begin
         mag[i] >>= k;
         sum += mag[i] * mag[i];
      end
      n = int_sqrt(sum);
      r.w = '0; r.x = '0; r.y = '0; r.z = '0;
      r.zero_norm = (n == 0);
      if (n != 0) begin
         for (int i = 0; i < 4; i++) begin
            q = ((mag[i] << FRAC) + (n >> 1)) / n;
            if (neg[i]) begin
               if (q > 32768) q = 32768;
               v = -longint'(q);
            end else begin
               if (q > 32767) q = 32767;
               v = q;
            end
            case (i)
               0: r.w = v[15:0];
               1: r.x = v[15:0];
               2: r.y = v[15:0];
               default: r.z = v[15:0];
            endcase
         end
      end
      return r;
   endfunction

   function automatic req_item_type make_item(input logic action, input int w, input int x,
                                              input int y, input int z, input int t,
                                              input bit typed, input bit zn);
      req_item_type it;
      it.action = action;
      it.w = w[15:0]; it.x = x[15:0]; it.y = y[15:0]; it.z = z[15:0];
      it.t = t[16:0];
      it.typed = typed;
      it.known.w = '0; it.known.x = '0; it.known.y = '0; it.known.z = '0;
      it.known.zero_norm = zn;
      return it;
   endfunction

   function automatic int rand_comp();
      case ($urandom_range(5))
         0: return int'($signed($urandom_range(65535) - 32768));
         1: return $urandom_range(1) ? 16384 : -16384;
         default: return int'($urandom_range(32768)) - 16384;
      endcase
   endfunction

   function automatic int rand_param();
      case ($urandom_range(7))
         0: return $urandom_range(131071);
         1: return $urandom_range(1) ? 65536 : 0;
         default: return $urandom_range(65536);
      endcase
   endfunction

   function automatic req_item_type rand_item();
      if ($urandom_range(99) < 65)
         return make_item(1'b0, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                          $urandom_range(131071), 0, 0);
      return make_item(1'b1, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                       rand_param(), 0, 0);
   endfunction

   // Request side: valid set at most once per edge; loads shift the window, evaluates queue a blend.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (!cur_item.action) push_point(cur_item);
            else if (cur_item.typed) blend_q.push_back(cur_item.known);
            else blend_q.push_back(blend_at(cur_item.t));
         end
         if (!req_valid || req_ready) begin
            if (stim_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_item = stim_q.pop_front();
               req_valid   <= 1'b1;
               req_action  <= cur_item.action;
               req_point_w <= cur_item.w;
               req_point_x <= cur_item.x;
               req_point_y <= cur_item.y;
               req_point_z <= cur_item.z;
               req_param_t <= cur_item.t;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      blend_type e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (blend_q.size() == 0) begin
               $error("unexpected result transfer");
               fail_count++;
            end else begin
               e = blend_q.pop_front();
               if (rsp_out_w !== e.w) begin
                  $error("out_w expected %0d actual %0d", e.w, rsp_out_w); fail_count++;
               end
               if (rsp_out_x !== e.x) begin
                  $error("out_x expected %0d actual %0d", e.x, rsp_out_x); fail_count++;
               end
               if (rsp_out_y !== e.y) begin
                  $error("out_y expected %0d actual %0d", e.y, rsp_out_y); fail_count++;
               end
               if (rsp_out_z !== e.z) begin
                  $error("out_z expected %0d actual %0d", e.z, rsp_out_z); fail_count++;
               end
               if (rsp_zero_norm !== e.zero_norm) begin
                  $error("zero_norm expected %0d actual %0d", e.zero_norm, rsp_zero_norm);
                  fail_count++;
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("catmull_rom_quaternion_interp: mismatch");
            $finish;
         end
      end
   end

   task automatic drain();
      while (stim_q.size() != 0 || req_valid || blend_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_item_type directed[$];
      for (int i = 0; i < 4; i++)
         for (int j = 0; j < 4; j++) window[i][j] = 0;
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 0, 1, 1));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 131071, 1, 1));
      directed.push_back(make_item(1'b0, 16384, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 32768, 0, 0));
      directed.push_back(make_item(1'b0, -16384, 16384, -16384, 16384, 0, 0, 0));
      directed.push_back(make_item(1'b0, -32768, -32768, -32768, -32768, 0, 0, 0));
      directed.push_back(make_item(1'b0, 0, -16384, 0, 16384, 0, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 65536, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 1, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 65535, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 131071, 0, 0));
      directed.push_back(make_item(1'b0, 32767, 32767, 32767, 32767, 0, 0, 0));
      directed.push_back(make_item(1'b0, 16384, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_item(1'b1, -1, -1, -1, -1, 49152, 0, 0));
      for (int i = 0; i < 4; i++)
         directed.push_back(make_item(1'b0, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_item(1'b1, 0, 0, 0, 0, 16384, 1, 1));
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (directed[i]) stim_q.push_back(directed[i]);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
            default: begin send_idle_pct = 24; recv_stall_pct = 24; end
         endcase
         for (int i = 0; i < 132; i++) stim_q.push_back(rand_item());
         drain();
      end
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("catmull_rom_quaternion_interp: match");
      else $display("catmull_rom_quaternion_interp: mismatch");
      $finish;
   end

endmodule
